// ----- design/rwh_pkg.sv -----
// RIFF WAVE header scanner: shared types, widths and signature constants.
// Used by every module of the scanner; depends on nothing.
package rwh_pkg;

  localparam int OFFSET_BITS = 40;
  localparam int TOTAL_BITS  = 48;
  localparam int LENGTH_BITS = 33;
  localparam int COUNT_BITS  = 32;
  localparam int SIZE_BITS   = 32;
  localparam int WIN_DEPTH   = 11;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Bytes of "RIFF" followed by "WAVE"
  localparam logic [7:0] SIG_R = 8'h52;
  localparam logic [7:0] SIG_I = 8'h49;
  localparam logic [7:0] SIG_F = 8'h46;
  localparam logic [7:0] SIG_W = 8'h57;
  localparam logic [7:0] SIG_A = 8'h41;
  localparam logic [7:0] SIG_V = 8'h56;
  localparam logic [7:0] SIG_E = 8'h45;

  localparam logic [LENGTH_BITS-1:0] HDR_EXTRA = LENGTH_BITS'(8);
  localparam logic [OFFSET_BITS-1:0] R_BACKSTEP = OFFSET_BITS'(WIN_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } rwh_in_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] match_offset;
    logic [LENGTH_BITS-1:0] file_length;
    logic [COUNT_BITS-1:0]  match_count;
    logic [TOTAL_BITS-1:0]  total_length;
  } rwh_out_t;

  // One found header passed from front to back
  typedef struct packed {
    logic                   clear;
    logic [OFFSET_BITS-1:0] offset;
    logic [LENGTH_BITS-1:0] length;
  } rwh_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rwh_q_stat_t;

endpackage

// ----- design/rwh_front.sv -----
// Front end of the scanner: byte window, position and signature detection.
// Depends on rwh_pkg.
module rwh_front import rwh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  rwh_in_t  in_data,
  output logic     rec_push,
  output rwh_rec_t rec
);

  logic [7:0]             win_r   [WIN_DEPTH];
  logic [7:0]             win_nxt [WIN_DEPTH];
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic                   clr_r, clr_nxt;
  logic [7:0]             view    [WIN_DEPTH+1];
  logic [OFFSET_BITS-1:0] base_pos;
  logic                   hit;

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      view[i] = in_data.stream_start ? 8'h00 : win_r[i];
    end
    view[WIN_DEPTH] = in_data.data_byte;
    base_pos = in_data.stream_start ? '0 : pos_r;
  end

  assign hit = (view[0] == SIG_R) && (view[1] == SIG_I) && (view[2] == SIG_F) &&
               (view[3] == SIG_F) && (view[8] == SIG_W) && (view[9] == SIG_A) &&
               (view[10] == SIG_V) && (view[11] == SIG_E);

  assign rec_push   = accept && hit;
  assign rec.clear  = clr_r || in_data.stream_start;
  assign rec.offset = base_pos - R_BACKSTEP;
  assign rec.length = LENGTH_BITS'({view[7], view[6], view[5], view[4]}) + HDR_EXTRA;

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_nxt[i] = win_r[i];
    end
    pos_nxt = pos_r;
    clr_nxt = clr_r;
    if (accept) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_nxt[i] = view[i+1];
      end
      pos_nxt = base_pos + OFFSET_BITS'(1);
      // hold a pending clear until the back end sees it with the next header
      clr_nxt = hit ? 1'b0 : (clr_r || in_data.stream_start);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= 8'h00;
      end
      pos_r <= '0;
      clr_r <= 1'b0;
    end else begin
      win_r <= win_nxt;
      pos_r <= pos_nxt;
      clr_r <= clr_nxt;
    end
  end

endmodule

// ----- design/rwh_queue.sv -----
// Short FIFO of found-header records between front and back ends.
// Depends on rwh_pkg.
module rwh_queue import rwh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr,
  input  rwh_rec_t    wr_rec,
  input  logic        rd,
  output rwh_rec_t    rd_rec,
  output rwh_q_stat_t stat
);

  rwh_rec_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign rd_rec     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- design/rwh_back.sv -----
// Back end of the scanner: saturating count and length total, result register.
// Depends on rwh_pkg.
module rwh_back import rwh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rwh_rec_t    rec,
  input  rwh_q_stat_t qstat,
  output logic        rec_pop,
  output logic        out_valid,
  input  logic        out_take,
  output rwh_out_t    out_data
);

  logic                  valid_r, valid_nxt;
  rwh_out_t              data_r, data_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt, base_count;
  logic [TOTAL_BITS-1:0] sum_r, sum_nxt, base_sum;
  logic [TOTAL_BITS:0]   sum_wide;

  assign rec_pop   = !qstat.empty && (!valid_r || out_take);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    base_count = rec.clear ? '0 : count_r;
    base_sum   = rec.clear ? '0 : sum_r;
    sum_wide   = {1'b0, base_sum} + (TOTAL_BITS+1)'(rec.length);
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    valid_nxt  = valid_r && !out_take;
    data_nxt   = data_r;
    if (rec_pop) begin
      // advance count, stick at the top
      count_nxt = (&base_count) ? base_count : base_count + COUNT_BITS'(1);
      sum_nxt   = sum_wide[TOTAL_BITS] ? '1 : sum_wide[TOTAL_BITS-1:0];
      valid_nxt = 1'b1;
      data_nxt.match_offset = rec.offset;
      data_nxt.file_length  = rec.length;
      data_nxt.match_count  = count_nxt;
      data_nxt.total_length = sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

// ----- design/riff_wave_header_scanner.sv -----
// RIFF WAVE header scanner, top level: front end, record FIFO, back end.
// Depends on rwh_pkg, rwh_front, rwh_queue and rwh_back.
//
// Usage:
//   Input channel: one file byte per word on in_data, with stream_start set on the
//   first byte of each file. A word is taken on a rising edge with push high and
//   full low. Output channel: one word per found "RIFF....WAVE" header; the oldest
//   result sits on out_data while empty is low and leaves on an edge with pop high.
//   Throughput: one byte per cycle while full is low, whether or not it completes a header.
//   A byte that completes a header has its result written into the record FIFO
//   and then moved into the result register.
//   The front end registers the window and position; found headers go into a
//   four-entry FIFO; the back end adds the count and total and holds the result.
//   When pop stays low, results back up into the FIFO; full rises only once the
//   FIFO holds four headers, and bytes that carry no header keep flowing until then.
//   Reset (rst_n low, synchronous) clears window, position, count, total, the record
//   FIFO and the result register; stream_start does the same for window, position, count and total.
module riff_wave_header_scanner import rwh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  rwh_in_t  in_data,
  output logic     empty,
  input  logic     pop,
  output rwh_out_t out_data
);

  logic        accept;
  logic        q_push, q_pop;
  rwh_rec_t    q_in, q_out;
  rwh_q_stat_t q_stat;
  logic        out_valid;

  // hold input while the record FIFO has no room
  assign full   = q_stat.full;
  assign accept = push && !full;
  assign empty  = !out_valid;

  rwh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .rec_push (q_push),
    .rec      (q_in)
  );

  rwh_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_push),
    .wr_rec (q_in),
    .rd     (q_pop),
    .rd_rec (q_out),
    .stat   (q_stat)
  );

  rwh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (q_out),
    .qstat     (q_stat),
    .rec_pop   (q_pop),
    .out_valid (out_valid),
    .out_take  (pop),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("header record pushed into a full FIFO");

  a_count_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.match_count != '0))
    else $error("result shown with zero match count");

  a_total_covers_length : assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.total_length >= TOTAL_BITS'(out_data.file_length)))
    else $error("running total below this header's length");

  a_pop_refills : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !q_stat.empty) |=> !empty)
    else $error("waiting record not moved into the result register");
`endif

endmodule
